// ----- hw/rtl/gsct_pkg.sv -----
package gsct_pkg;

  // Table geometry and message layout.
  localparam int TABLE_ENTRIES = 1024;
  localparam int MAP_BYTES     = 16;
  localparam int LIST_START    = 3;

  localparam logic [4:0] IDX_TYPE       = 5'd2;
  localparam logic [4:0] IDX_LIST_FIRST = 5'(LIST_START);
  localparam logic [4:0] IDX_LIST_LAST  = 5'(LIST_START + MAP_BYTES - 1);
  localparam logic [4:0] IDX_MAX        = 5'd31;

  // Message types.
  localparam logic [7:0] MSG_TYPE_LIST = 8'h1a;
  localparam logic [7:0] MSG_TYPE_ID   = 8'h1b;
  localparam logic [7:0] MSG_TYPE_AREA = 8'h1c;

  // Neighbour list format tests.
  localparam logic [7:0] FMT_BM0_MASK = 8'hc0;
  localparam logic [7:0] FMT_BM0_CODE = 8'h00;
  localparam logic [7:0] FMT_VAR_MASK = 8'hce;
  localparam logic [7:0] FMT_VAR_CODE = 8'h8e;
  localparam logic [9:0] BM0_ORIGIN   = 10'd125;

  typedef enum logic [1:0] {
    ACT_BURST = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_NEIGHBOUR = 2'd0,
    KIND_RECORD    = 2'd1,
    KIND_READ      = 2'd2
  } kind_e;

  typedef struct packed {
    logic        valid;
    logic [15:0] ident;
    logic [15:0] area;
    logic [3:0]  net;
    logic [7:0]  pwr;
  } rec_t;

  typedef struct packed {
    logic accept;
    logic clear_start;
    logic clear_step;
    logic scan_step;
    logic rd_issue;
    logic wr_merge;
    logic emit_rec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic    scan_need;
    logic    merge_need;
    logic    scan_bit_zero;
    logic    merge_pend;
    logic    clear_last;
    logic    out_free;
    action_e action;
  } dp_status_t;

endpackage

// ----- hw/rtl/gsm_sysinfo_cell_table_top.sv -----
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_ready_o  action, arfcn, power, data_byte, message_last
// out      output     out_valid_o / out_ready_i  kind, serving_arfcn, neighbour_arfcn,
//                                              entry_valid, cell_identity, area_code,
//                                              network_code, signal_level, run_last
//
// A message byte is accepted, then each scanned bit of a neighbour list byte is stepped
// (up to eight, set by the bit sequencer) while the output register is free, then the
// record memory is read and written back when the byte ends a message of a known type.
// Burst reports and record reads use the single memory port through the read and write states.
// After reset, and after each clear beat, a clearing pass writes all 1024 records;
// no input beat is accepted during it.
// A stalled output beat holds the sequencer; input waits while results remain to issue.
module gsm_sysinfo_cell_table_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic [9:0]        arfcn_i,
  input  logic signed [7:0] power_i,
  input  logic [7:0]        data_byte_i,
  input  logic              message_last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        kind_o,
  output logic [9:0]        serving_arfcn_o,
  output logic [9:0]        neighbour_arfcn_o,
  output logic              entry_valid_o,
  output logic [15:0]       cell_identity_o,
  output logic [15:0]       area_code_o,
  output logic [3:0]        network_code_o,
  output logic signed [7:0] signal_level_o,
  output logic              run_last_o
);

  // The controller sequences each beat; the datapath holds the parser state,
  // the record memory with its valid flag in every word, and the output register.
  gsct_pkg::ctrl_cmd_t  cmd;
  gsct_pkg::dp_status_t status;

  gsct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gsct_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .action_i          (action_i),
    .arfcn_i           (arfcn_i),
    .power_i           (power_i),
    .data_byte_i       (data_byte_i),
    .message_last_i    (message_last_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .kind_o            (kind_o),
    .serving_arfcn_o   (serving_arfcn_o),
    .neighbour_arfcn_o (neighbour_arfcn_o),
    .entry_valid_o     (entry_valid_o),
    .cell_identity_o   (cell_identity_o),
    .area_code_o       (area_code_o),
    .network_code_o    (network_code_o),
    .signal_level_o    (signal_level_o),
    .run_last_o        (run_last_o)
  );

  // A result beat is only produced when the output register can take it.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.scan_step || cmd.emit_rec) |-> status.out_free)
    else $error("result beat produced while output register is full");

  // A new beat never starts while a memory read is in flight.
  a_rmw_atomic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_issue |=> !cmd.accept)
    else $error("input accepted during record read-modify-write");

  // The clearing pass owns the memory port.
  a_clear_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !cmd.clear_step)
    else $error("input ready during clearing pass");

  // A clear beat always leads into the clearing pass.
  a_clear_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear_start |=> (!in_ready_o && cmd.clear_step))
    else $error("clear beat did not start the clearing pass");

endmodule

// ----- hw/rtl/gsct_ctrl.sv -----
module gsct_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [1:0]             action_i,
  output logic                   in_ready_o,
  input  gsct_pkg::dp_status_t   status_i,
  output gsct_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_RD    = 5'b01000,
    S_WR    = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          case (gsct_pkg::action_e'(action_i))
            gsct_pkg::ACT_CLEAR: begin
              cmd_o.clear_start = 1'b1;
              state_d = S_CLEAR;
            end
            gsct_pkg::ACT_BYTE: begin
              if (status_i.scan_need) begin
                state_d = S_SCAN;
              end else if (status_i.merge_need) begin
                state_d = S_RD;
              end
            end
            default: begin
              state_d = S_RD;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (status_i.out_free) begin
          cmd_o.scan_step = 1'b1;
          if (status_i.scan_bit_zero) begin
            state_d = status_i.merge_pend ? S_RD : S_IDLE;
          end
        end
      end
      S_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d = S_WR;
      end
      S_WR: begin
        case (status_i.action)
          gsct_pkg::ACT_BURST: begin
            cmd_o.wr_merge = 1'b1;
            state_d = S_IDLE;
          end
          gsct_pkg::ACT_READ: begin
            if (status_i.out_free) begin
              cmd_o.emit_rec = 1'b1;
              state_d = S_IDLE;
            end
          end
          default: begin
            if (status_i.out_free) begin
              cmd_o.wr_merge = 1'b1;
              cmd_o.emit_rec = 1'b1;
              state_d = S_IDLE;
            end
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hw/rtl/gsct_datapath.sv -----
module gsct_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gsct_pkg::ctrl_cmd_t   cmd_i,
  output gsct_pkg::dp_status_t  status_o,
  input  logic [1:0]            action_i,
  input  logic [9:0]            arfcn_i,
  input  logic signed [7:0]     power_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  message_last_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [1:0]            kind_o,
  output logic [9:0]            serving_arfcn_o,
  output logic [9:0]            neighbour_arfcn_o,
  output logic                  entry_valid_o,
  output logic [15:0]           cell_identity_o,
  output logic [15:0]           area_code_o,
  output logic [3:0]            network_code_o,
  output logic signed [7:0]     signal_level_o,
  output logic                  run_last_o
);

  // Byte positions of the identity, network and area fields, and of the variable list bytes.
  localparam logic [4:0] IdIdHi   = 5'd3;
  localparam logic [4:0] IdIdLo   = 5'd4;
  localparam logic [4:0] IdNet    = 5'd7;
  localparam logic [4:0] IdAreaHi = 5'd8;
  localparam logic [4:0] IdAreaLo = 5'd9;
  localparam logic [4:0] ArNet    = 5'd5;
  localparam logic [4:0] ArAreaHi = 5'd6;
  localparam logic [4:0] ArAreaLo = 5'd7;
  localparam logic [4:0] VarMid   = 5'(gsct_pkg::LIST_START + 1);
  localparam logic [4:0] VarFirst = 5'(gsct_pkg::LIST_START + 2);

  // Parser state.
  logic [4:0]  bidx_q, bidx_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  fmt_q, fmt_d;
  logic [9:0]  run_q, run_d;
  logic [15:0] pid_q, pid_d;
  logic [15:0] parea_q, parea_d;
  logic [3:0]  pnet_q, pnet_d;
  logic [2:0]  bit_q, bit_d;
  logic        dir_up_q, dir_up_d;
  logic        merge_pend_q, merge_pend_d;
  logic [9:0]  clr_cnt_q;
  logic        out_valid_q;

  // Item held while it is worked on.
  gsct_pkg::action_e act_q;
  logic [9:0]        arfcn_q;
  logic [7:0]        power_q;
  logic [7:0]        byte_q;

  gsct_pkg::rec_t mem_q [gsct_pkg::TABLE_ENTRIES];
  gsct_pkg::rec_t rd_q;
  gsct_pkg::rec_t merged;

  logic [1:0]  out_kind_q;
  logic [9:0]  out_srv_q;
  logic [9:0]  out_nb_q;
  logic        out_ev_q;
  logic [15:0] out_id_q;
  logic [15:0] out_area_q;
  logic [3:0]  out_net_q;
  logic [7:0]  out_pwr_q;
  logic        out_last_q;

  logic [7:0] type_n, fmt_n;
  logic       in_list, bm0, vb, type_known;
  logic [4:0] idx;
  logic       out_free, nb_emit, nb_last;
  logic [7:0] below;

  assign idx = bidx_q;

  // Decode of the byte at the input, against the parser state.
  always_comb begin
    if (idx == 5'd0) begin
      type_n = 8'h00;
    end else if (idx == gsct_pkg::IDX_TYPE) begin
      type_n = data_byte_i;
    end else begin
      type_n = type_q;
    end
    in_list = (type_n == gsct_pkg::MSG_TYPE_LIST) && (idx >= gsct_pkg::IDX_LIST_FIRST)
              && (idx <= gsct_pkg::IDX_LIST_LAST);
    fmt_n = (in_list && idx == gsct_pkg::IDX_LIST_FIRST) ? data_byte_i : fmt_q;
    bm0 = (fmt_n & gsct_pkg::FMT_BM0_MASK) == gsct_pkg::FMT_BM0_CODE;
    vb  = (fmt_n & gsct_pkg::FMT_VAR_MASK) == gsct_pkg::FMT_VAR_CODE;
    type_known = (type_n == gsct_pkg::MSG_TYPE_ID) || (type_n == gsct_pkg::MSG_TYPE_AREA)
                 || (type_n == gsct_pkg::MSG_TYPE_LIST);
  end

  always_comb begin
    bidx_d       = bidx_q;
    type_d       = type_q;
    fmt_d        = fmt_q;
    run_d        = run_q;
    pid_d        = pid_q;
    parea_d      = parea_q;
    pnet_d       = pnet_q;
    bit_d        = bit_q;
    dir_up_d     = dir_up_q;
    merge_pend_d = merge_pend_q;
    if (cmd_i.accept) begin
      case (gsct_pkg::action_e'(action_i))
        gsct_pkg::ACT_CLEAR: begin
          bidx_d       = '0;
          type_d       = '0;
          fmt_d        = '0;
          run_d        = '0;
          pid_d        = '0;
          parea_d      = '0;
          pnet_d       = '0;
          merge_pend_d = 1'b0;
        end
        gsct_pkg::ACT_BYTE: begin
          type_d = type_n;
          fmt_d  = fmt_n;
          if (idx == 5'd0) begin
            pid_d   = '0;
            parea_d = '0;
            pnet_d  = '0;
          end else if (type_n == gsct_pkg::MSG_TYPE_ID) begin
            if (idx == IdIdHi)   pid_d[15:8]   = data_byte_i;
            if (idx == IdIdLo)   pid_d[7:0]    = data_byte_i;
            if (idx == IdNet)    pnet_d        = data_byte_i[7:4];
            if (idx == IdAreaHi) parea_d[15:8] = data_byte_i;
            if (idx == IdAreaLo) parea_d[7:0]  = data_byte_i;
          end else if (type_n == gsct_pkg::MSG_TYPE_AREA) begin
            if (idx == ArNet)    pnet_d        = data_byte_i[7:4];
            if (idx == ArAreaHi) parea_d[15:8] = data_byte_i;
            if (idx == ArAreaLo) parea_d[7:0]  = data_byte_i;
          end
          if (in_list && bm0) begin
            if (idx == gsct_pkg::IDX_LIST_FIRST) begin
              run_d = gsct_pkg::BM0_ORIGIN;
              bit_d = 3'd3;
            end else begin
              bit_d = 3'd7;
            end
            dir_up_d = 1'b0;
          end else if (in_list && vb) begin
            dir_up_d = 1'b1;
            bit_d    = 3'd7;
            if (idx == gsct_pkg::IDX_LIST_FIRST) begin
              run_d = {data_byte_i[0], 9'd0};
            end else if (idx == VarMid) begin
              run_d = {run_q[9], data_byte_i, 1'b0};
            end else if (idx == VarFirst) begin
              run_d = {run_q[9:1], data_byte_i[7]};
              bit_d = 3'd6;
            end
          end
          merge_pend_d = message_last_i && type_known;
          if (message_last_i) begin
            bidx_d = '0;
          end else if (idx < gsct_pkg::IDX_MAX) begin
            bidx_d = idx + 5'd1;
          end
        end
        default: begin
          merge_pend_d = 1'b0;
        end
      endcase
    end else if (cmd_i.scan_step) begin
      run_d = dir_up_q ? run_q + 10'd1 : run_q - 10'd1;
      bit_d = bit_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bidx_q       <= '0;
      type_q       <= '0;
      fmt_q        <= '0;
      run_q        <= '0;
      pid_q        <= '0;
      parea_q      <= '0;
      pnet_q       <= '0;
      bit_q        <= '0;
      dir_up_q     <= 1'b0;
      merge_pend_q <= 1'b0;
      clr_cnt_q    <= '0;
    end else begin
      bidx_q       <= bidx_d;
      type_q       <= type_d;
      fmt_q        <= fmt_d;
      run_q        <= run_d;
      pid_q        <= pid_d;
      parea_q      <= parea_d;
      pnet_q       <= pnet_d;
      bit_q        <= bit_d;
      dir_up_q     <= dir_up_d;
      merge_pend_q <= merge_pend_d;
      if (cmd_i.clear_start) begin
        clr_cnt_q <= '0;
      end else if (cmd_i.clear_step) begin
        clr_cnt_q <= clr_cnt_q + 10'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q   <= gsct_pkg::action_e'(action_i);
      arfcn_q <= arfcn_i;
      power_q <= power_i;
      byte_q  <= data_byte_i;
    end
  end

  // Merge of the new fields into the stored record; nonzero fields win.
  always_comb begin
    logic        is_msg;
    logic [15:0] new_id;
    logic [15:0] new_area;
    logic [3:0]  new_net;
    is_msg   = (act_q == gsct_pkg::ACT_BYTE);
    new_id   = (is_msg && type_q == gsct_pkg::MSG_TYPE_ID) ? pid_q : 16'd0;
    new_area = (is_msg && type_q != gsct_pkg::MSG_TYPE_LIST) ? parea_q : 16'd0;
    new_net  = (is_msg && type_q != gsct_pkg::MSG_TYPE_LIST) ? pnet_q : 4'd0;
    merged.valid = 1'b1;
    merged.ident = (new_id != 16'd0) ? new_id : (rd_q.valid ? rd_q.ident : 16'd0);
    merged.area  = (new_area != 16'd0) ? new_area : (rd_q.valid ? rd_q.area : 16'd0);
    merged.net   = (new_net != 4'd0) ? new_net : (rd_q.valid ? rd_q.net : 4'd0);
    merged.pwr   = (power_q != 8'd0) ? power_q : (rd_q.valid ? rd_q.pwr : 8'd0);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step) begin
      mem_q[clr_cnt_q] <= '0;
    end else if (cmd_i.wr_merge) begin
      mem_q[arfcn_q] <= merged;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      rd_q <= mem_q[arfcn_q];
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign nb_emit  = cmd_i.scan_step && byte_q[bit_q];
  assign below    = byte_q & ((8'd1 << bit_q) - 8'd1);
  assign nb_last  = (below == 8'd0) && !merge_pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (nb_emit || cmd_i.emit_rec) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (nb_emit) begin
      out_kind_q <= gsct_pkg::KIND_NEIGHBOUR;
      out_srv_q  <= arfcn_q;
      out_nb_q   <= run_d;
      out_ev_q   <= 1'b0;
      out_id_q   <= '0;
      out_area_q <= '0;
      out_net_q  <= '0;
      out_pwr_q  <= '0;
      out_last_q <= nb_last;
    end else if (cmd_i.emit_rec) begin
      out_srv_q  <= arfcn_q;
      out_nb_q   <= '0;
      out_last_q <= 1'b1;
      if (act_q == gsct_pkg::ACT_READ) begin
        out_kind_q <= gsct_pkg::KIND_READ;
        out_ev_q   <= rd_q.valid;
        out_id_q   <= rd_q.valid ? rd_q.ident : 16'd0;
        out_area_q <= rd_q.valid ? rd_q.area : 16'd0;
        out_net_q  <= rd_q.valid ? rd_q.net : 4'd0;
        out_pwr_q  <= rd_q.valid ? rd_q.pwr : 8'd0;
      end else begin
        out_kind_q <= gsct_pkg::KIND_RECORD;
        out_ev_q   <= 1'b1;
        out_id_q   <= merged.ident;
        out_area_q <= merged.area;
        out_net_q  <= merged.net;
        out_pwr_q  <= merged.pwr;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = out_kind_q;
  assign serving_arfcn_o   = out_srv_q;
  assign neighbour_arfcn_o = out_nb_q;
  assign entry_valid_o     = out_ev_q;
  assign cell_identity_o   = out_id_q;
  assign area_code_o       = out_area_q;
  assign network_code_o    = out_net_q;
  assign signal_level_o    = $signed(out_pwr_q);
  assign run_last_o        = out_last_q;

  always_comb begin
    status_o               = '0;
    status_o.scan_need     = in_list && (bm0 || (vb && idx >= VarFirst));
    status_o.merge_need    = message_last_i && type_known;
    status_o.scan_bit_zero = (bit_q == 3'd0);
    status_o.merge_pend    = merge_pend_q;
    status_o.clear_last    = &clr_cnt_q;
    status_o.out_free      = out_free;
    status_o.action        = act_q;
  end

endmodule
